[sv/mqfd_pkg.sv]
// Shared types, constants and the packet type check for the MQTT fixed-header deframer.
// It has no dependencies. The core, the output stage and the top level import it.
`default_nettype none

package mqfd_pkg;

    localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;
    localparam logic [15:0] BUFFER_SIZE_RESET    = 16'd1024;

    localparam int unsigned LEN_W = 28;
    localparam int unsigned CNT_W = 3;

    // Phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // Frame status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADLEN  = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
    localparam logic [1:0] ST_BADTYPE = 2'd3;

    // Keep-alive action codes
    localparam logic [1:0] KA_NONE    = 2'd0;
    localparam logic [1:0] KA_PING    = 2'd1;
    localparam logic [1:0] KA_PUBLISH = 2'd2;

    // Packet type nibbles
    localparam logic [3:0] KIND_CONNACK  = 4'd2;
    localparam logic [3:0] KIND_PUBLISH  = 4'd3;
    localparam logic [3:0] KIND_PUBACK   = 4'd4;
    localparam logic [3:0] KIND_PUBREC   = 4'd5;
    localparam logic [3:0] KIND_PUBREL   = 4'd6;
    localparam logic [3:0] KIND_PUBCOMP  = 4'd7;
    localparam logic [3:0] KIND_SUBACK   = 4'd9;
    localparam logic [3:0] KIND_UNSUBACK = 4'd11;
    localparam logic [3:0] KIND_PINGRESP = 4'd13;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [3:0] packet_kind;
        logic       frame_done;
        logic [1:0] frame_status;
        logic [1:0] keepalive_action;
    } result_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] action;
    } frame_end_t;

    // Type check at the end of a frame that fits the buffer.
    function automatic frame_end_t check_kind(input logic [3:0] kind);
        frame_end_t r;
        unique case (kind)
            KIND_CONNACK, KIND_PUBREC, KIND_PUBREL, KIND_PUBCOMP:
            begin
                r.status = ST_OK;
                r.action = KA_NONE;
            end
            KIND_PUBACK, KIND_SUBACK, KIND_UNSUBACK, KIND_PINGRESP:
            begin
                r.status = ST_OK;
                r.action = KA_PING;
            end
            KIND_PUBLISH:
            begin
                r.status = ST_OK;
                r.action = KA_PUBLISH;
            end
            default:
            begin
                r.status = ST_BADTYPE;
                r.action = KA_NONE;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/mqfd_core.sv]
// Deframer state and the per-byte next-state logic for one received byte.
// It depends on mqfd_pkg and produces one result word for each accepted byte.
`default_nettype none

module mqfd_core #(
    parameter int unsigned MAX_LENGTH_BYTES = mqfd_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [15:0]       buffer_size,
    output mqfd_pkg::result_t      result
);
    import mqfd_pkg::*;

    logic [1:0]       phase_reg, phase_next;
    logic [3:0]       kind_reg, kind_next;
    logic [LEN_W-1:0] accum_reg, accum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic             discard_reg, discard_next;

    logic [CNT_W-1:0] cnt_inc;
    logic [1:0]       group_idx;
    logic [LEN_W-1:0] addend;
    logic [LEN_W-1:0] accum_sum;
    logic [LEN_W:0]   total;
    logic             too_long;
    logic [LEN_W-1:0] left_dec;
    frame_end_t       kind_chk;

    always_comb
    begin
        cnt_inc   = count_reg + CNT_W'(1);
        group_idx = cnt_inc[1:0] - 2'd1;
        // Length groups are seven bits each, least significant first.
        unique case (group_idx)
            2'd0:    addend = {21'd0, rx_byte[6:0]};
            2'd1:    addend = {14'd0, rx_byte[6:0], 7'd0};
            2'd2:    addend = {7'd0, rx_byte[6:0], 14'd0};
            default: addend = {rx_byte[6:0], 21'd0};
        endcase
        accum_sum = accum_reg + addend;
        total     = {1'b0, accum_sum} + (LEN_W + 1)'(cnt_inc) + (LEN_W + 1)'(1);
        too_long  = total >= {(LEN_W - 15)'(0), buffer_size};
        left_dec  = left_reg - LEN_W'(1);
        kind_chk  = check_kind(kind_reg);
    end

    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        accum_next   = accum_reg;
        count_next   = count_reg;
        left_next    = left_reg;
        discard_next = discard_reg;

        result                  = '0;
        result.packet_kind      = kind_reg;

        unique case (phase_reg)
            PH_LENGTH:
            begin
                count_next = cnt_inc;
                accum_next = accum_sum;
                if (rx_byte[7])
                begin
                    if (cnt_inc >= CNT_W'(MAX_LENGTH_BYTES))
                    begin
                        result.frame_done   = 1'b1;
                        result.frame_status = ST_BADLEN;
                        phase_next          = PH_HEADER;
                    end
                end
                else
                begin
                    left_next = accum_sum;
                    if (accum_sum == '0)
                    begin
                        result.frame_done = 1'b1;
                        if (too_long)
                        begin
                            result.frame_status = ST_SHORT;
                        end
                        else
                        begin
                            result.frame_status     = kind_chk.status;
                            result.keepalive_action = kind_chk.action;
                        end
                        discard_next = 1'b0;
                        phase_next   = PH_HEADER;
                    end
                    else
                    begin
                        discard_next = too_long;
                        phase_next   = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (!discard_reg)
                begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = rx_byte;
                end
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    result.frame_done = 1'b1;
                    if (discard_reg)
                    begin
                        result.frame_status = ST_SHORT;
                    end
                    else
                    begin
                        result.frame_status     = kind_chk.status;
                        result.keepalive_action = kind_chk.action;
                    end
                    discard_next = 1'b0;
                    phase_next   = PH_HEADER;
                end
            end
            default:
            begin
                // Header byte; the unused phase code also lands here.
                kind_next          = rx_byte[7:4];
                result.packet_kind = rx_byte[7:4];
                accum_next         = '0;
                count_next         = '0;
                left_next          = '0;
                discard_next       = 1'b0;
                phase_next         = PH_LENGTH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            kind_reg    <= '0;
            accum_reg   <= '0;
            count_reg   <= '0;
            left_reg    <= '0;
            discard_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            accum_reg   <= accum_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            discard_reg <= discard_next;
        end
    end

endmodule

`default_nettype wire

[sv/mqfd_out.sv]
// Output register stage that holds one result word until the downstream side takes it.
// It depends on mqfd_pkg for the result word type.
`default_nettype none

module mqfd_out (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mqfd_pkg::result_t in_result,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mqfd_pkg::result_t      out_result
);
    import mqfd_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // A new word may enter when the stage is empty or the held one leaves in the same cycle.
    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_result;
        end
    end

endmodule

`default_nettype wire

[sv/mqtt_frame_deframer.sv]
// Top level of the MQTT fixed-header deframer: configuration register, core and output stage.
// It depends on mqfd_pkg, mqfd_core and mqfd_out.
//
//  Group   Direction  Width  Contents
//  s_*     in         8      received byte
//  m_*     out        16+5+1 payload byte, status, keep-alive; tuser kind/valid; tlast
//  cfg_*   in         16     buffer size in bytes
//
// One byte is accepted per cycle while the output is not stalled, and its result appears in the next cycle.
// The rate is set by the update of the deframer state, which is done once for each byte.
// Reset returns the block to the header phase with a buffer size of 1024 bytes.
// A stalled output holds its word and the input takes a byte only when the word leaves.
`default_nettype none

module mqtt_frame_deframer #(
    parameter int unsigned MAX_LENGTH_BYTES = mqfd_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] payload_byte, [9:8] frame_status,
                                        // [11:10] keepalive_action, [15:12] zero
    output logic [4:0]       m_tuser,   // [0] payload_valid, [4:1] packet_kind
    output logic             m_tlast,   // frame_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // buffer_size
);
    import mqfd_pkg::*;

    logic [15:0] buffer_size_reg;
    logic        advance;
    result_t     core_result;
    result_t     out_result;

    assign cfg_ready = 1'b1;
    assign advance   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= BUFFER_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            buffer_size_reg <= cfg_data;
        end
    end

    mqfd_core #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .rx_byte     (s_tdata),
        .buffer_size (buffer_size_reg),
        .result      (core_result)
    );

    mqfd_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_result  (core_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {4'd0, out_result.keepalive_action, out_result.frame_status,
                      out_result.payload_byte};
    assign m_tuser = {out_result.packet_kind, out_result.payload_valid};
    assign m_tlast = out_result.frame_done;

endmodule

`default_nettype wire

[sv/mqfd_checker.sv]
// Port-level checks for the MQTT fixed-header deframer, bound to the top level.
// It depends only on the ports of mqtt_frame_deframer.
`default_nettype none

module mqfd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [4:0]  m_tuser,
    input wire logic        m_tlast
);

    // A word that is not kept payload carries a zero data byte.
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'd0))
        else $error("payload byte nonzero without payload_valid");

    // A status other than ok only appears at the end of a frame.
    a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[9:8] != 2'd0)) |-> m_tlast)
        else $error("frame status set outside a frame end");

    // A keep-alive action only comes with a successful frame end.
    a_ka_ok_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[11:10] != 2'd0)) |->
            (m_tlast && (m_tdata[9:8] == 2'd0) && (m_tdata[11:10] != 2'd3)))
        else $error("keep-alive action without a clean frame end");

    // A stalled word stays in place.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("output word changed while stalled");

endmodule

bind mqtt_frame_deframer mqfd_checker u_mqfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[verif/tb_mqtt_frame_deframer.sv]
// Self-checking testbench for mqtt_frame_deframer: streams link bytes in, predicts every
// output word with a behavioral model of the deframer and compares each field.
// Depends on mqfd_pkg and the mqtt_frame_deframer RTL.
module tb_mqtt_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import mqfd_pkg::*;

    // Type nibbles that no valid packet uses.
    localparam logic [3:0] KIND_RESERVED_LO = 4'd0;
    localparam logic [3:0] KIND_RESERVED_HI = 4'd15;

    class deframer_model;
        logic [15:0] buffer_size;
        logic [1:0]  phase;
        logic [3:0]  kind;
        logic [27:0] length_accum;
        logic [2:0]  length_count;
        logic [27:0] bytes_left;
        bit          discarding;
        result_t     expected_words[$];
        int unsigned errors;

        function new();
            buffer_size  = BUFFER_SIZE_RESET;
            phase        = PH_HEADER;
            kind         = '0;
            length_accum = '0;
            length_count = '0;
            bytes_left   = '0;
            discarding   = 1'b0;
            errors       = 0;
        endfunction

        // Closes a frame: an oversized one reports the short buffer, any other gets the
        // type check and its keep-alive action.
        function void finish_frame(inout result_t r);
            r.frame_done = 1'b1;
            if (discarding)
                r.frame_status = ST_SHORT;
            else
                case (kind)
                    KIND_PUBLISH:
                        r.keepalive_action = KA_PUBLISH;
                    KIND_PUBACK, KIND_SUBACK, KIND_UNSUBACK, KIND_PINGRESP:
                        r.keepalive_action = KA_PING;
                    KIND_CONNACK, KIND_PUBREC, KIND_PUBREL, KIND_PUBCOMP:
                        ;
                    default:
                        r.frame_status = ST_BADTYPE;
                endcase
            discarding = 1'b0;
            phase = PH_HEADER;
        endfunction

        function void take_rx_byte(input logic [7:0] b);
            result_t     r;
            int unsigned total;
            r = '0;
            case (phase)
                PH_LENGTH:
                begin
                    length_count = length_count + 3'd1;
                    length_accum = length_accum
                                   + (28'(b[6:0]) << (7 * ((length_count - 3'd1) & 3'd3)));
                    if (b[7])
                    begin
                        if (length_count >= MAX_LENGTH_BYTES_DEF)
                        begin
                            r.frame_done = 1'b1;
                            r.frame_status = ST_BADLEN;
                            phase = PH_HEADER;
                        end
                    end
                    else
                    begin
                        total = 1 + length_count + length_accum;
                        bytes_left = length_accum;
                        discarding = (total >= buffer_size);
                        if (bytes_left == 0)
                            finish_frame(r);
                        else
                            phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (!discarding)
                    begin
                        r.payload_valid = 1'b1;
                        r.payload_byte = b;
                    end
                    bytes_left = bytes_left - 28'd1;
                    if (bytes_left == 0)
                        finish_frame(r);
                end
                default:
                begin
                    kind = b[7:4];
                    length_accum = '0;
                    length_count = '0;
                    bytes_left = '0;
                    discarding = 1'b0;
                    phase = PH_LENGTH;
                end
            endcase
            r.packet_kind = kind;
            expected_words.push_back(r);
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(input result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t: output word %h arrived with nothing expected, actual %h",
                         $time, got, got);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("payload_valid", want.payload_valid, got.payload_valid);
            compare_field("packet_kind", want.packet_kind, got.packet_kind);
            compare_field("frame_done", want.frame_done, got.frame_done);
            compare_field("frame_status", want.frame_status, got.frame_status);
            compare_field("keepalive_action", want.keepalive_action, got.keepalive_action);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] payload_byte, [9:8] frame_status,
                                    // [11:10] keepalive_action, [15:12] zero
    logic [4:0]  m_tuser;           // [0] payload_valid, [4:1] packet_kind
    logic        m_tlast;           // frame_done
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;     // buffer_size

    int unsigned tx_idle_pct = 10;
    int unsigned rx_idle_pct = 79;
    int unsigned bytes_sent = 0;

    deframer_model model = new();

    logic [7:0] directed_bytes [25] = '{
        {KIND_PUBLISH, 4'h0}, 8'h02, 8'h00, 8'hFF,
        {KIND_PINGRESP, 4'h0}, 8'h00,
        {KIND_RESERVED_LO, 4'hF}, 8'h00,
        {KIND_RESERVED_HI, 4'h5}, 8'h01, 8'hA5,
        {KIND_CONNACK, 4'hA}, 8'h80, 8'h80, 8'h80, 8'h80,
        {KIND_PUBACK, 4'hC}, 8'h81, 8'h80, 8'h00, 8'h5A,
        {KIND_UNSUBACK, 4'h0}, 8'h00,
        {KIND_PUBREL, 4'h2}, 8'h00
    };

    mqtt_frame_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // Both handshakes are sampled with the values they held just before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                model.check_word(result_t'({m_tdata[7:0], m_tuser[0], m_tuser[4:1], m_tlast,
                                            m_tdata[9:8], m_tdata[11:10]}));
            if (s_tvalid && s_tready)
                model.take_rx_byte(s_tdata);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends one complete packet, so that the next one always starts in the header phase.
    task automatic send_frame();
        int unsigned mode;
        int unsigned len;
        int unsigned nlen;
        logic [3:0]  kind;
        logic [7:0]  b;
        mode = $urandom_range(99);
        if (mode < 12)
        begin
            // Broken length: the continuation bit is still set on the last allowed byte.
            send_byte(8'($urandom_range(255)));
            for (int i = 0; i < MAX_LENGTH_BYTES_DEF; i++)
                send_byte({1'b1, 7'($urandom_range(127))});
            return;
        end
        if (mode < 85)
            case ($urandom_range(8))
                0: kind = KIND_CONNACK;
                1: kind = KIND_PUBLISH;
                2: kind = KIND_PUBACK;
                3: kind = KIND_PUBREC;
                4: kind = KIND_PUBREL;
                5: kind = KIND_PUBCOMP;
                6: kind = KIND_SUBACK;
                7: kind = KIND_UNSUBACK;
                default: kind = KIND_PINGRESP;
            endcase
        else
            kind = 4'($urandom_range(15));
        send_byte({kind, 4'($urandom_range(15))});
        len = ($urandom_range(19) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        nlen = (len < 128) ? 1 : 2;
        // Some packets carry padded, non-minimal length encodings.
        if ($urandom_range(3) == 0)
            nlen = $urandom_range(nlen, MAX_LENGTH_BYTES_DEF);
        for (int i = 0; i < nlen; i++)
        begin
            b = 8'((len >> (7 * i)) & 127);
            b[7] = (i < nlen - 1);
            send_byte(b);
        end
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic write_buffer_size(input logic [15:0] size);
        s_tvalid <= 1'b0;
        while (model.expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= size;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model.buffer_size = size;
    endtask

    initial
    begin
        int unsigned target;
        logic [15:0] size;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: size = 16'hFFFF;
                1: size = 16'd1;
                2: size = 16'd0;
                3: size = 16'd20;
                4: size = 16'd8;
                5: size = 16'($urandom_range(9, 40));
                6: size = BUFFER_SIZE_RESET;
                default: size = 16'($urandom_range(1, 65535));
            endcase
            write_buffer_size(size);
            if (p < 3)
            begin
                tx_idle_pct = 10;
                rx_idle_pct = 79;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 79;
                rx_idle_pct = 10;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            target = bytes_sent + 90;
            while (bytes_sent < target)
                send_frame();
        end
        s_tvalid <= 1'b0;

        while (model.expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (model.errors == 0 && model.expected_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
